// ===== design/jsv_pkg.sv =====
// Package: shared types, character constants and helper functions of the JSON scalar validator.
`default_nettype none
package jsv_pkg;

  // Scanner phase
  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_LIT     = 4'd1,
    PH_NEG     = 4'd2,
    PH_INT     = 4'd3,
    PH_ZERO    = 4'd4,
    PH_FRAC1   = 4'd5,
    PH_FRAC    = 4'd6,
    PH_EXP1    = 4'd7,
    PH_EXPSIGN = 4'd8,
    PH_EXP     = 4'd9,
    PH_TRAIL   = 4'd10,
    PH_ERROR   = 4'd11
  } phase_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EXPECT_VALUE = 2'd1,
    ST_INVALID      = 2'd2,
    ST_NOT_SINGULAR = 2'd3
  } status_e;

  // Value kinds; literal choice uses the same codes
  typedef enum logic [1:0] {
    KIND_NULL   = 2'd0,
    KIND_FALSE  = 2'd1,
    KIND_TRUE   = 2'd2,
    KIND_NUMBER = 2'd3
  } kind_e;

  // Scanner state carried from byte to byte
  typedef struct packed {
    phase_e      phase;
    kind_e       lit_choice;
    logic [2:0]  lit_pos;
    status_e     status;
    kind_e       kind;
  } scan_state_t;

  // Result of one terminator byte
  typedef struct packed {
    status_e status;
    kind_e   kind;
  } scan_result_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:      PH_LEAD,
    lit_choice: KIND_NULL,
    lit_pos:    3'd0,
    status:     ST_OK,
    kind:       KIND_NULL
  };

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_T  = 8'h74;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Length of each literal in letters
  function automatic logic [2:0] lit_len(input kind_e choice);
    logic [2:0] len;
    unique case (choice)
      KIND_FALSE: len = 3'd5;
      KIND_NULL:  len = 3'd4;
      KIND_TRUE:  len = 3'd4;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  // Letter of a literal at a position; NUL past the end
  function automatic logic [7:0] lit_char(input kind_e choice, input logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    unique case (choice)
      KIND_NULL: begin
        unique case (pos)
          3'd0:    c = 8'h6E; // n
          3'd1:    c = 8'h75; // u
          3'd2:    c = 8'h6C; // l
          3'd3:    c = 8'h6C; // l
          default: c = CH_NUL;
        endcase
      end
      KIND_FALSE: begin
        unique case (pos)
          3'd0:    c = 8'h66; // f
          3'd1:    c = 8'h61; // a
          3'd2:    c = 8'h6C; // l
          3'd3:    c = 8'h73; // s
          3'd4:    c = 8'h65; // e
          default: c = CH_NUL;
        endcase
      end
      KIND_TRUE: begin
        unique case (pos)
          3'd0:    c = 8'h74; // t
          3'd1:    c = 8'h72; // r
          3'd2:    c = 8'h75; // u
          3'd3:    c = 8'h65; // e
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/jsv_if.sv =====
// Interfaces: byte input channel and result output channel of the validator.
`default_nettype none
interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface jsv_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] parse_status;
  logic [1:0] value_kind;

  modport source (output valid, output parse_status, output value_kind, input ready);
  modport sink   (input valid, input parse_status, input value_kind, output ready);
endinterface
`default_nettype wire

// ===== design/jsv_step.sv =====
// Scanner step: next state and result for one byte of a JSON scalar document.
`default_nettype none
module jsv_step (
  input  jsv_pkg::scan_state_t  state_i,
  input  logic [7:0]            byte_i,
  output jsv_pkg::scan_state_t  state_o,
  output jsv_pkg::scan_result_t result_o
);

  logic       b_space;
  logic       b_digit;
  logic       b_exp;
  logic [2:0] pos_inc;

  assign b_space = jsv_pkg::is_space(byte_i);
  assign b_digit = jsv_pkg::is_digit(byte_i);
  assign b_exp   = (byte_i == jsv_pkg::CH_LO_E) || (byte_i == jsv_pkg::CH_UP_E);
  assign pos_inc = state_i.lit_pos + 3'd1;

  // Result on the terminator, from the phase reached
  always_comb begin
    result_o.kind = jsv_pkg::KIND_NULL;
    unique case (state_i.phase)
      jsv_pkg::PH_LEAD:  result_o.status = jsv_pkg::ST_EXPECT_VALUE;
      jsv_pkg::PH_INT, jsv_pkg::PH_ZERO, jsv_pkg::PH_FRAC, jsv_pkg::PH_EXP: begin
        result_o.status = jsv_pkg::ST_OK;
        result_o.kind   = jsv_pkg::KIND_NUMBER;
      end
      jsv_pkg::PH_TRAIL: begin
        result_o.status = jsv_pkg::ST_OK;
        result_o.kind   = state_i.kind;
      end
      jsv_pkg::PH_ERROR: result_o.status = state_i.status;
      default:           result_o.status = jsv_pkg::ST_INVALID;
    endcase
  end

  // Next state; first error latches, terminator clears
  always_comb begin
    state_o = state_i;
    if (byte_i == jsv_pkg::CH_NUL) begin
      state_o = jsv_pkg::SCAN_RESET;
    end else begin
      unique case (state_i.phase)
        jsv_pkg::PH_LEAD: begin
          if (b_space) begin
            state_o.phase = jsv_pkg::PH_LEAD;
          end else if (byte_i == jsv_pkg::CH_LO_N) begin
            state_o.lit_choice = jsv_pkg::KIND_NULL;
            state_o.lit_pos    = 3'd1;
            state_o.phase      = jsv_pkg::PH_LIT;
          end else if (byte_i == jsv_pkg::CH_LO_F) begin
            state_o.lit_choice = jsv_pkg::KIND_FALSE;
            state_o.lit_pos    = 3'd1;
            state_o.phase      = jsv_pkg::PH_LIT;
          end else if (byte_i == jsv_pkg::CH_LO_T) begin
            state_o.lit_choice = jsv_pkg::KIND_TRUE;
            state_o.lit_pos    = 3'd1;
            state_o.phase      = jsv_pkg::PH_LIT;
          end else if (byte_i == jsv_pkg::CH_MINUS) begin
            state_o.phase = jsv_pkg::PH_NEG;
          end else if (byte_i == jsv_pkg::CH_ZERO) begin
            state_o.phase = jsv_pkg::PH_ZERO;
          end else if (b_digit) begin
            state_o.phase = jsv_pkg::PH_INT;
          end else begin
            state_o.status = jsv_pkg::ST_INVALID;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        jsv_pkg::PH_LIT: begin
          if ((state_i.lit_choice == jsv_pkg::KIND_NUMBER)
              || (state_i.lit_pos >= jsv_pkg::lit_len(state_i.lit_choice))
              || (jsv_pkg::lit_char(state_i.lit_choice, state_i.lit_pos) != byte_i)) begin
            state_o.status = jsv_pkg::ST_INVALID;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end else begin
            state_o.lit_pos = pos_inc;
            if (pos_inc == jsv_pkg::lit_len(state_i.lit_choice)) begin
              state_o.kind  = state_i.lit_choice;
              state_o.phase = jsv_pkg::PH_TRAIL;
            end
          end
        end
        jsv_pkg::PH_NEG: begin
          if (byte_i == jsv_pkg::CH_ZERO) begin
            state_o.phase = jsv_pkg::PH_ZERO;
          end else if (b_digit) begin
            state_o.phase = jsv_pkg::PH_INT;
          end else begin
            state_o.status = jsv_pkg::ST_INVALID;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        jsv_pkg::PH_INT, jsv_pkg::PH_ZERO, jsv_pkg::PH_FRAC: begin
          if ((state_i.phase != jsv_pkg::PH_ZERO) && b_digit) begin
            state_o.phase = state_i.phase;
          end else if ((state_i.phase != jsv_pkg::PH_FRAC) && (byte_i == jsv_pkg::CH_DOT)) begin
            state_o.phase = jsv_pkg::PH_FRAC1;
          end else if (b_exp) begin
            state_o.phase = jsv_pkg::PH_EXP1;
          end else if (b_space) begin
            state_o.kind  = jsv_pkg::KIND_NUMBER;
            state_o.phase = jsv_pkg::PH_TRAIL;
          end else begin
            state_o.status = jsv_pkg::ST_NOT_SINGULAR;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        jsv_pkg::PH_FRAC1, jsv_pkg::PH_EXPSIGN: begin
          if (b_digit) begin
            state_o.phase = (state_i.phase == jsv_pkg::PH_FRAC1) ? jsv_pkg::PH_FRAC
                                                                 : jsv_pkg::PH_EXP;
          end else begin
            state_o.status = jsv_pkg::ST_INVALID;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        jsv_pkg::PH_EXP1: begin
          if ((byte_i == jsv_pkg::CH_PLUS) || (byte_i == jsv_pkg::CH_MINUS)) begin
            state_o.phase = jsv_pkg::PH_EXPSIGN;
          end else if (b_digit) begin
            state_o.phase = jsv_pkg::PH_EXP;
          end else begin
            state_o.status = jsv_pkg::ST_INVALID;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        jsv_pkg::PH_EXP: begin
          if (b_digit) begin
            state_o.phase = jsv_pkg::PH_EXP;
          end else if (b_space) begin
            state_o.kind  = jsv_pkg::KIND_NUMBER;
            state_o.phase = jsv_pkg::PH_TRAIL;
          end else begin
            state_o.status = jsv_pkg::ST_NOT_SINGULAR;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        jsv_pkg::PH_TRAIL: begin
          if (!b_space) begin
            state_o.status = jsv_pkg::ST_NOT_SINGULAR;
            state_o.kind   = jsv_pkg::KIND_NULL;
            state_o.phase  = jsv_pkg::PH_ERROR;
          end
        end
        default: begin
          // error phase and unused codes: bytes ignored until the terminator
          state_o = state_i;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/json_scalar_validator_core.sv =====
// Top level: JSON scalar validator with input register, scanner step and result register.
//
// Usage: bytes of a JSON text arrive on in_i, one word per byte; a zero byte
// ends the document. The block skips whitespace, matches one scalar (true,
// false, null or a JSON number) and, for each terminator only, sends one word
// on out_o carrying parse_status and value_kind. Other bytes give no word.
// Order: a byte taken is first held in the input register, then scanned; a
// terminator's result is then loaded into the result register on out_o.
// Throughput: one byte per cycle while no terminator stalls, set by the
// combinational scanner step between the input register and the state register.
// Stall: a terminator waits in the input register while the result register
// is full and not taken; in_i.ready then falls. Non-terminator bytes keep
// flowing while a result waits, since they produce no word.
// Reset (rst_ni low, asynchronous): both registers empty, scanner back in
// the leading whitespace phase with no error latched.
`default_nettype none
module json_scalar_validator_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  jsv_in_if.sink     in_i,
  jsv_out_if.source  out_o
);

  logic                  in_vld_q;
  logic [7:0]            byte_q;
  jsv_pkg::scan_state_t  state_q;
  jsv_pkg::scan_state_t  state_d;
  jsv_pkg::scan_result_t result_d;
  logic                  out_vld_q;
  jsv_pkg::scan_result_t result_q;
  logic                  is_term;
  logic                  advance;
  logic                  out_load;

  // Scanner step
  jsv_step u_step (
    .state_i  (state_q),
    .byte_i   (byte_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Stage control: a terminator needs room in the result register
  assign is_term  = (byte_q == jsv_pkg::CH_NUL);
  assign advance  = !in_vld_q || !is_term || !out_vld_q || out_o.ready;
  assign out_load = in_vld_q && is_term && advance;
  assign in_i.ready = advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (advance) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_i.valid) begin
      byte_q <= in_i.text_byte;
    end
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsv_pkg::SCAN_RESET;
    end else if (in_vld_q && advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.parse_status = result_q.status;
  assign out_o.value_kind   = result_q.kind;

  // Checks
  a_err_kind_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (result_q.status != jsv_pkg::ST_OK)) |-> (result_q.kind == jsv_pkg::KIND_NULL))
    else $error("error result carries a value kind");

  a_err_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == jsv_pkg::PH_ERROR) |-> (state_q.status != jsv_pkg::ST_OK))
    else $error("error phase without latched status");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((state_q.phase == jsv_pkg::PH_LEAD) && (state_q.status == jsv_pkg::ST_OK)))
    else $error("scanner not cleared after terminator");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire
